// ----- rtl/core/clrc_pkg.sv -----
// clrc_pkg: shared types and constants for the character LCD refresh controller.
// Holds request codes, register indexes, display command bytes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package clrc_pkg;

  localparam int DEF_BUFFER_DEPTH = 32;

  // Request codes carried on in_req_type.
  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_WRITE     = 3'd1;
  localparam logic [2:0] REQ_CLEAR     = 3'd2;
  localparam logic [2:0] REQ_RESET_POS = 3'd3;
  localparam logic [2:0] REQ_INIT      = 3'd4;
  localparam logic [2:0] REQ_FLAG      = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE1       = 2'd0;
  localparam logic [1:0] CFG_MODE2       = 2'd1;
  localparam logic [1:0] CFG_SECOND_LINE = 2'd2;

  // Control flag selects.
  localparam logic [1:0] FLAG_BLINK   = 2'd0;
  localparam logic [1:0] FLAG_CURSOR  = 2'd1;
  localparam logic [1:0] FLAG_DISPLAY = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] MODE1_RST       = 8'h08;
  localparam logic [7:0] MODE2_RST       = 8'h04;
  localparam logic [6:0] SECOND_LINE_RST = 7'd64;

  // Display command bytes and special characters.
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  // Last step of each nibble sequence.
  localparam logic [3:0] TICK_LAST_STEP = 4'd3;
  localparam logic [3:0] INIT_LAST_STEP = 4'd11;
  localparam logic [3:0] FLAG_LAST_STEP = 4'd1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TICK = 4'b0010,
    ST_INIT = 4'b0100,
    ST_FLAG = 4'b1000
  } clrc_state_t;

endpackage

// ----- rtl/core/char_lcd_refresh_controller_core.sv -----
// Top level of the character LCD refresh controller: screen buffer memory, refresh
// position, control byte and the nibble sequencer. Depends on clrc_pkg.
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------------------------
//   request   | start, busy            | in_req_type, in_entry_index, in_entry_char,
//             |                        | in_flag_select, in_flag_value
//   result    | out_valid (strobe)     | out_reg_select, out_nibble, out_last
//   config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A tick runs four sequencer steps, one per nibble, and a new transfer is taken only once
// busy is low again, since busy drops only after the final step. Init and set flag also run
// the sequencer; write, clear and reset-position requests leave busy low.
// One nibble leaves per cycle, each one registered, so the first nibble reaches the result
// ports through the sequencer state register and then the output registers.
// Reset (synchronous, active low) marks every buffer entry as a space through per-entry
// valid bits, so no clearing pass is needed. The receiver cannot stall results.
`timescale 1ns / 1ps

module char_lcd_refresh_controller_core
  import clrc_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [4:0] in_entry_index,
  input  logic [7:0] in_entry_char,
  input  logic [1:0] in_flag_select,
  input  logic       in_flag_value,
  output logic       out_valid,
  output logic       out_reg_select,
  output logic [3:0] out_nibble,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int HALF  = BUFFER_DEPTH / 2;
  localparam int POS_W = $clog2(BUFFER_DEPTH);
  localparam int COL_W = (HALF > 1) ? $clog2(HALF) : 1;

  clrc_state_t state_r, state_nxt;
  logic [3:0]       step_r, step_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [BUFFER_DEPTH-1:0] valid_r, valid_nxt;
  logic [7:0] disp_ctrl_r, disp_ctrl_nxt;
  logic [7:0] mode1_r;
  logic [7:0] mode2_r;
  logic [6:0] second_line_r;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_valid_r;
  logic [7:0] addr_cmd_r;

  logic       out_valid_r;
  logic       out_reg_select_r;
  logic [3:0] out_nibble_r;
  logic       out_last_r;

  logic accept;
  logic do_tick;
  logic do_write;
  logic [POS_W-1:0] wr_addr;
  logic [7:0] addr_sum;
  logic [7:0] chr;
  logic [7:0] seq_byte;
  logic       seq_rs;
  logic [3:0] raw_nib;
  logic       use_raw;
  logic       seq_last;
  logic [3:0] seq_nib;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign do_tick   = accept && (in_req_type == REQ_TICK);
  assign do_write  = accept && (in_req_type == REQ_WRITE) &&
                     (32'(in_entry_index) < BUFFER_DEPTH);
  assign wr_addr   = POS_W'(in_entry_index);

  // Display RAM address of the current position: the second row starts at second_line_r.
  assign addr_sum = ((pos_r >= POS_W'(HALF)) ? {1'b0, second_line_r} : 8'd0) + 8'(col_r);

  // Screen buffer: one write port for entry writes, one registered read for ticks.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= in_entry_char;
    end
    if (do_tick) begin
      rd_data_r  <= mem[pos_r];
      rd_valid_r <= valid_r[pos_r];
      addr_cmd_r <= CMD_SET_ADDR | addr_sum;
    end
  end

  // Entries never written since the last clear read as spaces.
  assign chr = rd_valid_r ? rd_data_r : SPACE_CHAR;

  always_comb begin
    seq_byte = 8'd0;
    seq_rs   = 1'b0;
    raw_nib  = 4'd0;
    use_raw  = 1'b0;
    seq_last = 1'b0;
    case (state_r)
      ST_TICK: begin
        if (!step_r[1]) begin
          seq_byte = addr_cmd_r;
        end else if (chr == CHAR_FF) begin
          seq_byte = CMD_CLEAR;
        end else if (chr inside {CHAR_LF, CHAR_CR}) begin
          seq_byte = CMD_SET_ADDR | {1'b0, second_line_r};
        end else begin
          seq_byte = chr;
          seq_rs   = 1'b1;
        end
        seq_last = (step_r == TICK_LAST_STEP);
      end
      ST_INIT: begin
        case (step_r[3:1])
          3'd0, 3'd1: begin
            use_raw = 1'b1;
            raw_nib = (step_r == 4'd3) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE;
          end
          3'd2:    seq_byte = CMD_FUNCTION_SET | mode1_r;
          3'd3:    seq_byte = CMD_DISPLAY_CTRL | mode2_r;
          3'd4:    seq_byte = CMD_CLEAR;
          3'd5:    seq_byte = CMD_ENTRY_MODE;
          default: seq_byte = 8'd0;
        endcase
        seq_last = (step_r == INIT_LAST_STEP);
      end
      ST_FLAG: begin
        seq_byte = disp_ctrl_r;
        seq_last = (step_r == FLAG_LAST_STEP);
      end
      default: seq_byte = 8'd0;
    endcase
    // Bytes go out high nibble first, on the even step.
    seq_nib = use_raw ? raw_nib : (step_r[0] ? seq_byte[3:0] : seq_byte[7:4]);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    col_nxt       = col_r;
    valid_nxt     = valid_r;
    disp_ctrl_nxt = disp_ctrl_r;
    if (busy) begin
      step_nxt = step_r + 4'd1;
      if (seq_last) begin
        state_nxt = ST_IDLE;
      end
    end else if (accept) begin
      step_nxt = 4'd0;
      case (in_req_type)
        REQ_TICK: begin
          state_nxt = ST_TICK;
          if (pos_r == POS_W'(BUFFER_DEPTH - 1)) begin
            pos_nxt = '0;
            col_nxt = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
            col_nxt = (col_r == COL_W'(HALF - 1)) ? '0 : col_r + 1'b1;
          end
        end
        REQ_WRITE: begin
          if (do_write) begin
            valid_nxt[wr_addr] = 1'b1;
          end
        end
        REQ_CLEAR: begin
          valid_nxt = '0;
          pos_nxt   = '0;
          col_nxt   = '0;
        end
        REQ_RESET_POS: begin
          pos_nxt = '0;
          col_nxt = '0;
        end
        REQ_INIT: begin
          state_nxt     = ST_INIT;
          valid_nxt     = '0;
          pos_nxt       = '0;
          col_nxt       = '0;
          disp_ctrl_nxt = CMD_DISPLAY_CTRL | mode2_r;
        end
        REQ_FLAG: begin
          state_nxt = ST_FLAG;
          case (in_flag_select)
            FLAG_BLINK:   disp_ctrl_nxt[0] = in_flag_value;
            FLAG_CURSOR:  disp_ctrl_nxt[1] = in_flag_value;
            FLAG_DISPLAY: disp_ctrl_nxt[2] = in_flag_value;
            default:      state_nxt = ST_IDLE;
          endcase
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= 4'd0;
      pos_r         <= '0;
      col_r         <= '0;
      valid_r       <= '0;
      disp_ctrl_r   <= 8'd0;
      mode1_r       <= MODE1_RST;
      mode2_r       <= MODE2_RST;
      second_line_r <= SECOND_LINE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      valid_r     <= valid_nxt;
      disp_ctrl_r <= disp_ctrl_nxt;
      out_valid_r <= busy;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE1:       mode1_r       <= cfg_data;
          CFG_MODE2:       mode2_r       <= cfg_data;
          CFG_SECOND_LINE: second_line_r <= cfg_data[6:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_reg_select_r <= seq_rs;
    out_nibble_r     <= seq_nib;
    out_last_r       <= seq_last;
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_reg_select_r;
  assign out_nibble     = out_nibble_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  // The sequencer only goes idle on the transfer that carries the final nibble.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last))
    else $error("sequencer went idle without a final nibble");

  // Every result strobe comes from a cycle in which the sequencer was running.
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an active sequence");

  // A tick transfer always starts a nibble sequence.
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_TICK)) |=> busy)
    else $error("tick transfer did not start the sequencer");
`endif

endmodule
